@@ rtl/rccm_pkg.sv @@
// ---------------------------------------------------------------------------
// rccm_pkg: shared types and constants of the RC charge capacitance meter
// Item and result payloads, configuration set, command queue entries,
// register indexes and the fixed-point constants of the measurement.
// ---------------------------------------------------------------------------
package rccm_pkg;

    // parameter defaults
    localparam int STORE_DEPTH_DEF   = 16384;
    localparam int CHANNEL_COUNT_DEF = 7;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_LOW_TH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SAMP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STRIDE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VREF      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VFINAL    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RES       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE      = 3'd6;

    // input operation codes
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_OVER_HIGH  = 2'd1;
    localparam logic [1:0] OP_BELOW_LOW  = 2'd2;

    // result kinds
    localparam logic KIND_PIN  = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    // shared divider: divisor width and quotient width
    localparam int DIVISOR_W = 61;
    localparam int QUOT_W    = 32;

    // 10^12 split into two 20-bit halves
    localparam logic [19:0] TERA_LO = 20'h51000;
    localparam logic [19:0] TERA_HI = 20'hE8D4A;

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // command queue depth
    localparam int CMDQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] sample_code;
        logic [3:0]  channel_number;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic        discharge_drive;
        logic [31:0] capacitance_ff;
        logic        measurement_valid;
        logic [14:0] run_length;
    } t_result;

    typedef struct packed {
        logic [11:0] low_threshold;
        logic [14:0] min_samples;
        logic [10:0] sample_stride;
        logic [12:0] vref_mv;
        logic [12:0] vfinal_mv;
        logic [19:0] resistance_kohm;
        logic [19:0] sample_rate_hz;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_OVER_HIGH,
        CMD_BELOW_LOW
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [11:0] code;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M_INIT,
        S_M_NUM,
        S_M_LOOP,
        S_M_RD1,
        S_M_RD2,
        S_M_CHK,
        S_M_DIVA,
        S_M_NORM,
        S_M_SQ,
        S_M_SQN,
        S_M_LN,
        S_M_LN2,
        S_M_DEN,
        S_M_DIVC,
        S_M_NEXT,
        S_M_MEAN,
        S_M_DIVM,
        S_M_DONE
    } t_back_state;

endpackage

@@ rtl/rccm_front.sv @@
// ---------------------------------------------------------------------------
// rccm_front: input side of the meter
// Accepts items, drops unused operations and samples of foreign channels,
// and turns the rest into commands for the command queue.
// ---------------------------------------------------------------------------
module rccm_front #(
    parameter int CHANNEL_COUNT = rccm_pkg::CHANNEL_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  rccm_pkg::t_item i_item,
    output logic           o_wr,
    output rccm_pkg::t_cmd o_cmd,
    input  logic           i_q_full
);
    import rccm_pkg::*;

    logic accept;
    logic keep;
    logic chan_ok;

    // queue back-pressure is the only stall source
    assign full   = i_q_full;
    assign accept = push && !full;

    // classify the item
    assign chan_ok = 5'(i_item.channel_number) < 5'(CHANNEL_COUNT);

    always_comb begin
        o_cmd.code = i_item.sample_code;
        o_cmd.kind = CMD_SAMPLE;
        keep       = 1'b0;
        case (i_item.operation)
            OP_SAMPLE: begin
                o_cmd.kind = CMD_SAMPLE;
                keep       = chan_ok;
            end
            OP_OVER_HIGH: begin
                o_cmd.kind = CMD_OVER_HIGH;
                keep       = 1'b1;
            end
            OP_BELOW_LOW: begin
                o_cmd.kind = CMD_BELOW_LOW;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_wr = accept && keep;

    // no command is written while the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |-> !i_q_full)
        else $error("command written into full queue");

endmodule

@@ rtl/rccm_fifo.sv @@
// ---------------------------------------------------------------------------
// rccm_fifo: command queue between front and back
// Small register queue that lets the input side run on while the back
// end measures.
// ---------------------------------------------------------------------------
module rccm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rccm_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output rccm_pkg::t_cmd o_data,
    output logic           o_valid
);
    import rccm_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_level;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_level == (PW+1)'(CMDQ_DEPTH);
    assign o_valid = r_level != '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_level <= r_level + 1'b1;
            else if (do_pop && !do_push) r_level <= r_level - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    a_level_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !(i_pop && o_valid)) |=>
            r_level == $past(r_level) + 1'b1)
        else $error("queue level did not grow on push");

endmodule

@@ rtl/rccm_div.sv @@
// ---------------------------------------------------------------------------
// rccm_div: shared restoring divider
// Gives a 32-bit quotient, one bit a cycle, saturating to all ones when
// the quotient would not fit or the divisor is zero.
// ---------------------------------------------------------------------------
module rccm_div #(
    parameter int DW = 70
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DW-1:0]                  i_dividend,
    input  logic [rccm_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [rccm_pkg::QUOT_W-1:0]    o_quot
);
    import rccm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_step;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_d;
    logic [QUOT_W-1:0]    r_low;
    logic [QUOT_W-1:0]    r_quot;
    logic [DIVISOR_W-1:0] hi;
    logic                 sat;
    logic [DIVISOR_W:0]   trial;
    logic                 qbit;

    // quotient overflows when the upper dividend part reaches the divisor
    assign hi  = DIVISOR_W'(i_dividend[DW-1:QUOT_W]);
    assign sat = (i_divisor == '0) || (hi >= i_divisor);

    assign trial = {r_rem, r_low[QUOT_W-1]};
    assign qbit  = trial >= {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !sat;
                r_done <= sat;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= hi;
            r_d    <= i_divisor;
            r_low  <= i_dividend[QUOT_W-1:0];
            r_quot <= '1;
        end else if (r_busy) begin
            r_rem <= qbit ? DIVISOR_W'(trial - {1'b0, r_d}) : trial[DIVISOR_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], qbit};
            if (r_step == 5'd31) r_quot <= {r_low[QUOT_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

@@ rtl/rccm_back.sv @@
// ---------------------------------------------------------------------------
// rccm_back: execution side of the meter
// Runs pin commands, fills the sample store during a charge, and walks a
// closed run pair by pair through log, divide and averaging steps.
// ---------------------------------------------------------------------------
module rccm_back #(
    parameter int STORE_DEPTH = rccm_pkg::STORE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rccm_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_valid,
    input  rccm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              empty,
    input  logic              pop,
    output rccm_pkg::t_result o_result
);
    import rccm_pkg::*;

    localparam int W_CNT = $clog2(STORE_DEPTH + 1);
    localparam int W_A   = $clog2(STORE_DEPTH);
    localparam int W_I   = W_CNT + 12;
    localparam int W_CW  = (W_CNT > 15) ? W_CNT : 15;
    localparam int W_SUM = W_CNT + 32;
    localparam int W_TP  = W_CNT + 20;
    localparam int W_N   = W_CNT + 40;
    localparam int DW    = W_CNT + 56;

    // control state
    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_charging;
    logic               r_run_closed;
    logic               r_pin_drive;
    logic [W_CNT-1:0]   r_count;
    logic               r_out_valid;
    t_result            r_out;

    // sample store
    logic [11:0]        r_store [STORE_DEPTH];
    logic [11:0]        r_rdata;

    // measurement registers
    logic [W_CNT-1:0]   r_mid;
    logic [W_CNT-1:0]   r_run;
    logic [10:0]        r_stride;
    logic [W_I-1:0]     r_i;
    logic [W_SUM-1:0]   r_sum;
    logic [W_CNT-1:0]   r_cnt;
    logic [39:0]        r_rate;
    logic [W_TP-1:0]    r_tp_lo;
    logic [W_TP-1:0]    r_tp_hi;
    logic [DW-1:0]      r_num;
    logic [24:0]        r_v0;
    logic [24:0]        r_vt;
    logic [31:0]        r_m;
    logic [4:0]         r_shift;
    logic [3:0]         r_k;
    logic [15:0]        r_frac;
    logic [63:0]        r_prod;
    logic [53:0]        r_lnprod;
    logic [40:0]        r_d_lo;
    logic [40:0]        r_d_hi;
    logic [31:0]        r_cap;
    logic               r_meas_ok;

    // combinational helpers
    logic               out_free;
    logic               is_sample;
    logic               smp_store;
    logic               smp_measure;
    logic               count_room;
    logic               count_ge_min;
    logic               i_ge_mid;
    logic [W_A-1:0]     addr_hi;
    logic [24:0]        vf;
    logic [25:0]        num;
    logic [25:0]        den;
    logic [25:0]        neg_num;
    logic [25:0]        neg_den;
    logic [24:0]        un;
    logic [24:0]        ud;
    logic               pair_skip;
    logic [32:0]        sq_sh;
    logic [21:0]        nlog2;
    logic [54:0]        ln_round;
    logic [20:0]        nl;
    logic [W_N-1:0]     tera_mid;
    logic [DIVISOR_W-1:0] den_prod;

    // outputs of the sequencer
    logic               mem_we;
    logic [W_A-1:0]     rd_addr;
    logic               emit;
    t_result            res;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    // command classification
    assign out_free     = !r_out_valid || pop;
    assign is_sample    = i_cmd.kind == CMD_SAMPLE;
    assign count_room   = r_count < W_CNT'(STORE_DEPTH);
    assign count_ge_min = W_CW'(r_count) >= W_CW'(i_cfg.min_samples);
    assign smp_store    = r_charging && (i_cmd.code > i_cfg.low_threshold);
    assign smp_measure  = !smp_store && !r_run_closed && count_ge_min;

    // pair walk
    assign i_ge_mid = r_i >= W_I'(r_mid);
    assign addr_hi  = W_A'(r_mid + W_CNT'(r_i));

    // log argument terms in mV * 4096
    assign vf        = {i_cfg.vfinal_mv, 12'd0};
    assign num       = {1'b0, vf} - {1'b0, r_vt};
    assign den       = {1'b0, vf} - {1'b0, r_v0};
    assign neg_num   = 26'd0 - num;
    assign neg_den   = 26'd0 - den;
    assign un        = num[25] ? neg_num[24:0] : num[24:0];
    assign ud        = den[25] ? neg_den[24:0] : den[24:0];
    assign pair_skip = (den == '0) || (num == '0) || (num[25] != den[25]) || (un >= ud);

    // log2 by repeated squaring, then scaling by ln 2
    assign sq_sh    = r_prod[63:31];
    assign nlog2    = {(6'(r_shift) + 6'd1), 16'd0} - {6'd0, r_frac};
    assign ln_round = {1'b0, r_lnprod} + 55'(32'h8000_0000);
    assign nl       = ln_round[52:32];

    // mid * 10^12 and the per-pair divisor
    assign tera_mid = {r_tp_hi, 20'd0} + W_N'(r_tp_lo);
    assign den_prod = {r_d_hi, 20'd0} + DIVISOR_W'(r_d_lo);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && is_sample && smp_measure) n_state = S_M_INIT;
            end
            S_M_INIT: n_state = S_M_NUM;
            S_M_NUM:  n_state = S_M_LOOP;
            S_M_LOOP: n_state = i_ge_mid ? S_M_MEAN : S_M_RD1;
            S_M_RD1:  n_state = S_M_RD2;
            S_M_RD2:  n_state = S_M_CHK;
            S_M_CHK:  n_state = pair_skip ? S_M_NEXT : S_M_DIVA;
            S_M_DIVA: begin
                if (div_done) n_state = (div_quot == '0) ? S_M_NEXT : S_M_NORM;
            end
            S_M_NORM: begin
                if (r_m[31]) n_state = S_M_SQ;
            end
            S_M_SQ:   n_state = S_M_SQN;
            S_M_SQN:  n_state = (r_k == 4'd15) ? S_M_LN : S_M_SQ;
            S_M_LN:   n_state = S_M_LN2;
            S_M_LN2:  n_state = S_M_DEN;
            S_M_DEN:  n_state = S_M_DIVC;
            S_M_DIVC: begin
                if (div_done) n_state = S_M_NEXT;
            end
            S_M_NEXT: n_state = S_M_LOOP;
            S_M_MEAN: n_state = (r_cnt == '0) ? S_M_DONE : S_M_DIVM;
            S_M_DIVM: begin
                if (div_done) n_state = S_M_DONE;
            end
            S_M_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_cmd_pop    = 1'b0;
        mem_we       = 1'b0;
        emit         = 1'b0;
        rd_addr      = r_i[W_A-1:0];
        div_start    = 1'b0;
        div_dividend = r_num;
        div_divisor  = den_prod;
        res          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (is_sample) begin
                        o_cmd_pop = 1'b1;
                        mem_we    = smp_store && count_room;
                    end else if (out_free) begin
                        o_cmd_pop           = 1'b1;
                        emit                = 1'b1;
                        res.result_kind     = KIND_PIN;
                        res.discharge_drive = i_cmd.kind == CMD_OVER_HIGH;
                    end
                end
            end
            S_M_RD1: rd_addr = addr_hi;
            S_M_CHK: begin
                if (!pair_skip) begin
                    div_start    = 1'b1;
                    div_dividend = DW'({un, 32'd0});
                    div_divisor  = DIVISOR_W'(ud);
                end
            end
            S_M_DEN: div_start = 1'b1;
            S_M_MEAN: begin
                if (r_cnt != '0) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(r_sum);
                    div_divisor  = DIVISOR_W'(r_cnt);
                end
            end
            S_M_DONE: begin
                if (out_free) begin
                    emit                  = 1'b1;
                    res.result_kind       = KIND_MEAS;
                    res.discharge_drive   = r_pin_drive;
                    res.capacitance_ff    = r_cap;
                    res.measurement_valid = r_meas_ok;
                    res.run_length        = 15'(r_run);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_charging   <= 1'b0;
            r_run_closed <= 1'b0;
            r_pin_drive  <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)     r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
            if (r_state == S_IDLE && o_cmd_pop) begin
                if (!is_sample) begin
                    r_charging  <= i_cmd.kind == CMD_BELOW_LOW;
                    r_pin_drive <= i_cmd.kind == CMD_OVER_HIGH;
                end else if (smp_store) begin
                    r_run_closed <= 1'b0;
                    if (count_room) r_count <= r_count + 1'b1;
                end else if (!smp_measure) begin
                    if (!count_ge_min) r_count <= '0;
                    r_run_closed <= 1'b1;
                end
            end
            if (r_state == S_M_DONE && out_free) begin
                r_count      <= '0;
                r_run_closed <= 1'b1;
            end
        end
    end

    // sample store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[r_count[W_A-1:0]] <= i_cmd.code;
        r_rdata <= r_store[rd_addr];
    end

    // measurement datapath
    always_ff @(posedge i_clk) begin
        if (emit) r_out <= res;
        case (r_state)
            S_IDLE: begin
                r_mid <= r_count >> 1;
                r_run <= r_count;
            end
            S_M_INIT: begin
                r_stride <= (i_cfg.sample_stride == '0) ? 11'd1 : i_cfg.sample_stride;
                r_rate   <= 40'(i_cfg.sample_rate_hz) * 40'(i_cfg.resistance_kohm);
                r_tp_lo  <= W_TP'(r_mid) * W_TP'(TERA_LO);
                r_tp_hi  <= W_TP'(r_mid) * W_TP'(TERA_HI);
                r_i      <= '0;
                r_sum    <= '0;
                r_cnt    <= '0;
            end
            S_M_NUM:  r_num <= {tera_mid, 16'd0};
            S_M_RD1:  r_v0  <= 25'(r_rdata) * 25'(i_cfg.vref_mv);
            S_M_RD2:  r_vt  <= 25'(r_rdata) * 25'(i_cfg.vref_mv);
            S_M_DIVA: begin
                r_m     <= div_quot;
                r_shift <= '0;
                r_k     <= '0;
                r_frac  <= '0;
            end
            S_M_NORM: begin
                if (!r_m[31]) begin
                    r_m     <= {r_m[30:0], 1'b0};
                    r_shift <= r_shift + 1'b1;
                end
            end
            S_M_SQ:   r_prod <= 64'(r_m) * 64'(r_m);
            S_M_SQN: begin
                if (sq_sh[32]) begin
                    r_m                  <= sq_sh[32:1];
                    r_frac[4'd15 - r_k]  <= 1'b1;
                end else begin
                    r_m <= sq_sh[31:0];
                end
                r_k <= r_k + 1'b1;
            end
            S_M_LN:   r_lnprod <= 54'(nlog2) * 54'(LN2_Q32);
            S_M_LN2: begin
                r_d_lo <= 41'(r_rate[19:0]) * 41'(nl);
                r_d_hi <= 41'(r_rate[39:20]) * 41'(nl);
            end
            S_M_DIVC: begin
                if (div_done && div_quot != '0) begin
                    r_sum <= r_sum + W_SUM'(div_quot);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_M_NEXT: r_i <= r_i + W_I'(r_stride);
            S_M_MEAN: begin
                r_cap     <= '0;
                r_meas_ok <= 1'b0;
            end
            S_M_DIVM: begin
                r_cap     <= div_quot;
                r_meas_ok <= 1'b1;
            end
            default: ;
        endcase
    end

    rccm_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    // squaring always starts from a normalized mantissa
    a_norm_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_SQ) |-> r_m[31])
        else $error("squaring of unnormalized mantissa");

    // a finished measurement is posted and the run is cleared
    a_meas_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_DONE && out_free) |=>
            (r_out_valid && r_out.result_kind == KIND_MEAS && r_count == '0))
        else $error("measurement result not posted");

    // store writes stay inside the store
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE && r_count < W_CNT'(STORE_DEPTH)))
        else $error("store write beyond depth");

endmodule

@@ rtl/rc_charge_capacitance_meter.sv @@
// ---------------------------------------------------------------------------
// rc_charge_capacitance_meter: capacitance meter over an RC charge curve
// Tracks charge and discharge events, stores converter samples while the
// capacitor charges, and reports the mean capacitance of each long run.
//
//   channel   direction  handshake             payload
//   item      in         push / full           i_item (t_item)
//   result    out        empty / pop           o_result (t_result)
//   config    in         i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// The idle back end takes samples off the command queue, and events once
// the result register is free; the command queue takes items at one per
// cycle while it has room. A measurement walks the run and, for each
// evaluated pair, does two store reads, a 32-step divide for the log
// argument, up to 31 normalize steps, 16 squarings and a 32-step divide
// for the pair value; a final 32-step divide forms the mean.
// Reset is synchronous, active low, and loads the register defaults.
// The input stalls when the command queue fills, either during a
// measurement or while a pin update waits for the result register.
// ---------------------------------------------------------------------------
module rc_charge_capacitance_meter #(
    parameter int STORE_DEPTH   = rccm_pkg::STORE_DEPTH_DEF,
    parameter int CHANNEL_COUNT = rccm_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  rccm_pkg::t_item                  i_item,
    output logic                             empty,
    input  logic                             pop,
    output rccm_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [rccm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rccm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import rccm_pkg::*;

    t_cfg r_cfg;
    logic q_wr;
    t_cmd q_wdata;
    logic q_full;
    logic q_valid;
    t_cmd q_rdata;
    logic q_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold   <= 12'd1500;
            r_cfg.min_samples     <= 15'd5000;
            r_cfg.sample_stride   <= 11'd50;
            r_cfg.vref_mv         <= 13'd1100;
            r_cfg.vfinal_mv       <= 13'd3300;
            r_cfg.resistance_kohm <= 20'd600000;
            r_cfg.sample_rate_hz  <= 20'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LOW_TH:   r_cfg.low_threshold   <= i_cfg_wdata[11:0];
                REG_MIN_SAMP: r_cfg.min_samples     <= i_cfg_wdata[14:0];
                REG_STRIDE:   r_cfg.sample_stride   <= i_cfg_wdata[10:0];
                REG_VREF:     r_cfg.vref_mv         <= i_cfg_wdata[12:0];
                REG_VFINAL:   r_cfg.vfinal_mv       <= i_cfg_wdata[12:0];
                REG_RES:      r_cfg.resistance_kohm <= i_cfg_wdata;
                REG_RATE:     r_cfg.sample_rate_hz  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // front end: accept and classify
    rccm_front #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .o_wr     (q_wr),
        .o_cmd    (q_wdata),
        .i_q_full (q_full)
    );

    // command queue
    rccm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_wr),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_valid (q_valid)
    );

    // back end: store, measure, report
    rccm_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_rdata),
        .o_cmd_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench of the RC charge capacitance meter
// Drives events and converter samples through the item queue, rewrites the
// configuration between phases, predicts every pin update and measurement
// and compares each popped result against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
    import rccm_pkg::*;

    localparam int DEPTH      = STORE_DEPTH_DEF;
    localparam int CHANNELS   = CHANNEL_COUNT_DEF;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 200;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [63:0] FULL_CAP = 64'hFFFF_FFFF;

    // meter behavior and store of predicted results
    class charge_meter_tracker;
        logic [11:0] low_th;
        logic [14:0] min_samp;
        logic [10:0] stride;
        logic [12:0] vref;
        logic [12:0] vfinal;
        logic [19:0] res_kohm;
        logic [19:0] rate_hz;
        bit          charging;
        bit          run_closed;
        bit          pin_drive;
        int unsigned stored;
        logic [11:0] samples [DEPTH];
        t_result     pending_results [$];
        int          mismatches;

        function new();
            low_th = 1500; min_samp = 5000; stride = 50; vref = 1100;
            vfinal = 3300; res_kohm = 600000; rate_hz = 10000;
            charging = 0; run_closed = 0; pin_drive = 1; stored = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_LOW_TH:   low_th   = val[11:0];
                REG_MIN_SAMP: min_samp = val[14:0];
                REG_STRIDE:   stride   = val[10:0];
                REG_VREF:     vref     = val[12:0];
                REG_VFINAL:   vfinal   = val[12:0];
                REG_RES:      res_kohm = val[19:0];
                REG_RATE:     rate_hz  = val[19:0];
                default: ;
            endcase
        endfunction

        // -ln(a / 2^32) in q16.16 via log2 by repeated squaring
        function logic [63:0] neg_ln(logic [63:0] a);
            int p;
            logic [63:0] m, frac, nl2;
            p = 31;
            while (p > 0 && a[p] == 1'b0) p--;
            m = a << (31 - p);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 31;
                if (m >= 64'h1_0000_0000) begin
                    m = m >> 1;
                    frac = frac | (64'h8000 >> k);
                end
            end
            nl2 = (64'(32 - p) << 16) - frac;
            return (nl2 * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
        endfunction

        // mean capacitance over the stored run
        function void measure(output logic [31:0] cap, output bit valid);
            int unsigned mid, step, i;
            longint vf, v0, vt, num, den;
            logic [63:0] un, ud, a, nl, rate_r, total, cnt, d;
            logic [127:0] prod, q;
            mid = stored / 2;
            step = (stride == 0) ? 1 : stride;
            vf = longint'(vfinal) * 4096;
            rate_r = 64'(rate_hz) * 64'(res_kohm);
            total = 0; cnt = 0;
            for (i = 0; i < mid; i += step) begin
                v0 = longint'(samples[i]) * longint'(vref);
                vt = longint'(samples[mid + i]) * longint'(vref);
                num = vf - vt; den = vf - v0;
                if (den == 0 || num == 0 || ((num < 0) != (den < 0))) continue;
                un = (num < 0) ? -num : num;
                ud = (den < 0) ? -den : den;
                if (un >= ud) continue;
                a = (un << 32) / ud;
                if (a == 0) continue;
                nl = neg_ln(a);
                d = rate_r * nl;
                prod = 128'(mid) * 128'd65536 * 128'd1000000000000;
                if (d == 0) q = 128'(FULL_CAP);
                else begin
                    q = prod / 128'(d);
                    if (q > 128'(FULL_CAP)) q = 128'(FULL_CAP);
                end
                if (q == 0) continue;
                total += q[63:0];
                cnt++;
            end
            valid = (cnt != 0);
            cap = (cnt != 0) ? 32'(total / cnt) : 32'd0;
        endfunction

        // advance the meter on one accepted item transaction
        function void take_item(t_item it);
            t_result r;
            logic [31:0] cap;
            bit valid;
            r = '0;
            if (it.operation == OP_OVER_HIGH || it.operation == OP_BELOW_LOW) begin
                charging = (it.operation == OP_BELOW_LOW);
                pin_drive = (it.operation == OP_OVER_HIGH);
                r.result_kind = KIND_PIN;
                r.discharge_drive = pin_drive;
                pending_results.push_back(r);
                return;
            end
            if (it.operation != OP_SAMPLE || it.channel_number >= CHANNELS) return;
            if (charging && it.sample_code > low_th) begin
                run_closed = 0;
                if (stored < DEPTH) begin
                    samples[stored] = it.sample_code;
                    stored++;
                end
                return;
            end
            if (!run_closed && stored >= min_samp) begin
                measure(cap, valid);
                r.result_kind = KIND_MEAS;
                r.discharge_drive = pin_drive;
                r.capacitance_ff = cap;
                r.measurement_valid = valid;
                r.run_length = 15'(stored);
                pending_results.push_back(r);
                stored = 0;
                run_closed = 1;
                return;
            end
            if (stored < min_samp) stored = 0;
            run_closed = 1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            mismatches++;
        endtask

        // compare one popped result transaction
        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result", 64'(got), 64'(0));
                return;
            end
            want = pending_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", 64'(got.result_kind), 64'(want.result_kind));
            if (got.discharge_drive !== want.discharge_drive)
                report("discharge_drive", 64'(got.discharge_drive),
                       64'(want.discharge_drive));
            if (got.capacitance_ff !== want.capacitance_ff)
                report("capacitance_ff", 64'(got.capacitance_ff),
                       64'(want.capacitance_ff));
            if (got.measurement_valid !== want.measurement_valid)
                report("measurement_valid", 64'(got.measurement_valid),
                       64'(want.measurement_valid));
            if (got.run_length !== want.run_length)
                report("run_length", 64'(got.run_length), 64'(want.run_length));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_item                 i_item;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    charge_meter_tracker meter;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;

    rc_charge_capacitance_meter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls plus long hold-off
    initial begin
        pop = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (pop && !empty) meter.check_result(o_result);
        end
    end

    // one item transaction, with a random idle gap before it
    task send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        meter.take_item(it);
    endtask

    task send_op(logic [1:0] op, logic [11:0] code, logic [3:0] chan);
        t_item it;
        it.operation = op;
        it.sample_code = code;
        it.channel_number = chan;
        send_item(it);
    endtask

    // wait until every prediction has come back and the back end is quiet
    task drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (meter.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        meter.write_reg(idx, val);
    endtask

    task load_cfg(int th, int mins, int strd, int vr, int vfin, int res, int rate);
        write_cfg(REG_LOW_TH, CFG_DATA_W'(th));
        write_cfg(REG_MIN_SAMP, CFG_DATA_W'(mins));
        write_cfg(REG_STRIDE, CFG_DATA_W'(strd));
        write_cfg(REG_VREF, CFG_DATA_W'(vr));
        write_cfg(REG_VFINAL, CFG_DATA_W'(vfin));
        write_cfg(REG_RES, CFG_DATA_W'(res));
        write_cfg(REG_RATE, CFG_DATA_W'(rate));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one charge run: start event, rising or random samples, then a close
    task charge_run(int len);
        int code, lt;
        lt = meter.low_th;
        send_op(OP_BELOW_LOW, 12'($urandom), 4'($urandom_range(CHANNELS - 1)));
        code = lt + 1 + $urandom_range(40);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0)
                send_op($urandom_range(1) ? OP_UNUSED : OP_SAMPLE, 12'($urandom),
                        4'($urandom_range(15, CHANNELS)));
            if ($urandom_range(1)) code = code + $urandom_range(60);
            else code = lt + 1 + $urandom_range(4094 - lt);
            if (code > 4095) code = 4095;
            if (code <= lt) code = lt + 1;
            send_op(OP_SAMPLE, 12'((lt >= 4095) ? $urandom : code),
                    4'($urandom_range(CHANNELS - 1)));
        end
        if ($urandom_range(1)) send_op(OP_OVER_HIGH, 12'($urandom), 4'($urandom));
        send_op(OP_SAMPLE, 12'($urandom_range(lt)), 4'($urandom_range(CHANNELS - 1)));
        if ($urandom_range(3) == 0)
            send_op(OP_SAMPLE, 12'($urandom_range(lt)), 4'($urandom_range(CHANNELS - 1)));
    endtask

    // random items: mostly well-formed runs, some noise
    task random_phase(int budget);
        int sent;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(4) == 0) begin
                send_op(2'($urandom), 12'($urandom), 4'($urandom));
                sent++;
            end else begin
                int len;
                len = meter.min_samp + $urandom_range(8) - 3;
                if (len < 1) len = 1;
                if (len > 60) len = $urandom_range(60);
                charge_run(len);
                sent += len + 3;
            end
        end
    endtask

    initial begin
        meter = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: events, ignored items, thresholds, short and closed runs
        load_cfg(1500, 3, 0, 1100, 3300, 600000, 10000);
        write_cfg(REG_UNUSED, 20'hFFFFF);
        i_cfg_we <= 1'b0;
        send_op(OP_UNUSED, 12'hFFF, 4'd0);
        send_op(OP_OVER_HIGH, 12'd0, 4'd15);
        send_op(OP_SAMPLE, 12'd4095, 4'd0);
        send_op(OP_BELOW_LOW, 12'hFFF, 4'hF);
        send_op(OP_SAMPLE, 12'd4095, 4'd15);
        send_op(OP_SAMPLE, 12'd1501, 4'd6);
        send_op(OP_SAMPLE, 12'd1500, 4'd0);
        send_op(OP_SAMPLE, 12'd0, 4'd0);
        send_op(OP_SAMPLE, 12'd1600, 4'd1);
        send_op(OP_SAMPLE, 12'd1800, 4'd2);
        send_op(OP_SAMPLE, 12'd2600, 4'd3);
        send_op(OP_SAMPLE, 12'd3400, 4'd4);
        send_op(OP_SAMPLE, 12'd4095, 4'd5);
        send_op(OP_OVER_HIGH, 12'd0, 4'd0);
        send_op(OP_SAMPLE, 12'd4095, 4'd0);
        send_op(OP_SAMPLE, 12'd0, 4'd0);
        drain();

        // extremes: opposite signs, unit rate and resistance
        load_cfg(0, 2, 1, 5000, 1, 1, 1);
        charge_run(6);
        charge_run(2);
        drain();
        load_cfg(4095, 2, 1024, 8191, 8191, 0, 0);
        charge_run(4);
        drain();

        // random phases across idling modes and settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            load_cfg($urandom_range(2500), $urandom_range(40, 2),
                     ($urandom_range(3) == 0) ? $urandom_range(1024) : $urandom_range(6, 1),
                     $urandom_range(5000, 1), $urandom_range(5000, 1),
                     $urandom_range(1000000, 1), $urandom_range(1000000, 1));
            if (ph == 2) begin
                // long hold-off so the queues fill and push stalls
                hold_cycles = 3000;
                for (int k = 0; k < 40; k++)
                    send_op($urandom_range(1) ? OP_OVER_HIGH : OP_BELOW_LOW,
                            12'($urandom), 4'($urandom));
            end
            random_phase(60);
            drain();
        end

        if (meter.mismatches == 0 && meter.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
